FILE: hdl/refract_direction_defines.svh
// ---------------------------------------------------------------------------
// refract_direction_defines.svh
// Assertion macros shared by the refraction datapath. Clock is clk and reset
// is rst_n in every module that uses them.
// ---------------------------------------------------------------------------
`ifndef REFRACT_DIRECTION_DEFINES_SVH
`define REFRACT_DIRECTION_DEFINES_SVH

// Same-cycle implication
`define RD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("refract_direction: same-cycle check failed");

// Next-cycle implication
`define RD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("refract_direction: next-cycle check failed");

// Implication after a fixed number of cycles
`define RD_ASSERT_AFTER(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("refract_direction: delayed check failed");

`endif

FILE: hdl/rd_pkg.sv
// ---------------------------------------------------------------------------
// rd_pkg
// Shared types and constants for the refraction datapath.
// ---------------------------------------------------------------------------
package rd_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_PASS = 2'd0,
    ST_TIR  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  // Transmission threshold after reset, units of 2^-30 (about 1e-6)
  localparam logic [30:0] THRESH_RESET = 31'd1074;

endpackage

FILE: hdl/rd_delay.sv
// ---------------------------------------------------------------------------
// rd_delay
// Fixed-length payload delay line that keeps side data aligned with the
// long arithmetic pipelines.
// ---------------------------------------------------------------------------
module rd_delay #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap_r [N];

  // Shift one tap per cycle
  always_ff @(posedge clk) begin
    tap_r[0] <= din;
    for (int k = 1; k < N; k++) begin
      tap_r[k] <= tap_r[k-1];
    end
  end

  assign dout = tap_r[N-1];

endmodule

FILE: hdl/rd_sqrt.sv
// ---------------------------------------------------------------------------
// rd_sqrt
// Pipelined digit-by-digit square root, one root bit per stage, followed by
// a round-to-nearest stage.
// ---------------------------------------------------------------------------
module rd_sqrt #(
  parameter int RAD_W = 62
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [RAD_W-1:0]   rad,
  output logic               out_vld,
  output logic [RAD_W/2:0]   root
);

  localparam int RES_W = RAD_W / 2;

  logic [RES_W-1:0] vld_r;
  logic [RAD_W-1:0] rad_r  [RES_W];
  logic [RES_W+1:0] rem_r  [RES_W];
  logic [RES_W-1:0] root_r [RES_W];

  for (genvar k = 0; k < RES_W; k++) begin : g_stage
    logic             vld_i;
    logic [RAD_W-1:0] rad_i;
    logic [RES_W+1:0] rem_i;
    logic [RES_W-1:0] root_i;
    logic [RES_W+1:0] rem_sh;
    logic [RES_W+1:0] trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rad_i  = rad;
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign rad_i  = rad_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
    end

    // Bring down two radicand bits, try the next root bit
    always_comb begin
      rem_sh = {rem_i[RES_W-1:0], rad_i[RAD_W-1 -: 2]};
      trial  = {root_i, 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      rad_r[k]  <= rad_i << 2;
      rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
      root_r[k] <= {root_i[RES_W-2:0], ge};
    end
  end

  // Round to nearest: bump when the remainder exceeds the root
  logic             rnd;
  logic             out_vld_r;
  logic [RES_W:0]   root_out_r;

  assign rnd = (rem_r[RES_W-1] > {2'b00, root_r[RES_W-1]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[RES_W-1];
    end
  end

  always_ff @(posedge clk) begin
    root_out_r <= {1'b0, root_r[RES_W-1]} + {{RES_W{1'b0}}, rnd};
  end

  assign out_vld = out_vld_r;
  assign root    = root_out_r;

endmodule

FILE: hdl/rd_div.sv
// ---------------------------------------------------------------------------
// rd_div
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// known to fit Q_W bits.
// ---------------------------------------------------------------------------
module rd_div #(
  parameter int NUM_W = 61,
  parameter int DEN_W = 31,
  parameter int Q_W   = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             out_vld,
  output logic [Q_W-1:0]   quo
);

  logic [Q_W-1:0]   vld_r;
  logic [DEN_W-1:0] rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   low_r [Q_W];
  logic [Q_W-1:0]   quo_r [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic             vld_i;
    logic [DEN_W-1:0] rem_i;
    logic [DEN_W-1:0] den_i;
    logic [Q_W-1:0]   low_i;
    logic [Q_W-1:0]   quo_i;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_i = in_vld;
      assign rem_i = DEN_W'(num[NUM_W-1:Q_W]);
      assign den_i = den;
      assign low_i = num[Q_W-1:0];
      assign quo_i = '0;
    end else begin : g_next
      assign vld_i = vld_r[k-1];
      assign rem_i = rem_r[k-1];
      assign den_i = den_r[k-1];
      assign low_i = low_r[k-1];
      assign quo_i = quo_r[k-1];
    end

    // Shift in one numerator bit and trial-subtract the divisor
    always_comb begin
      trial = {rem_i, low_i[Q_W-1]};
      diff  = trial - {1'b0, den_i};
      ge    = (trial >= {1'b0, den_i});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      den_r[k] <= den_i;
      low_r[k] <= low_i << 1;
      quo_r[k] <= {quo_i[Q_W-2:0], ge};
    end
  end

  assign out_vld = vld_r[Q_W-1];
  assign quo     = quo_r[Q_W-1];

endmodule

FILE: hdl/refract_direction.sv
// ---------------------------------------------------------------------------
// refract_direction
// Snell refraction of a ray direction against a unit normal, fixed point.
// ---------------------------------------------------------------------------
// One item is taken every cycle (busy stays low) and its result appears on
// the out_ ports, strobed by out_valid for one cycle. The pipeline is built
// from the two bit-per-stage square-root pipelines (32 and 33 stages) and
// the bit-per-stage divider (32 stages), plus fourteen registered stages
// around them. Results cannot be held off, so nothing in the pipeline ever
// stalls. The threshold register is written through the cfg_ port, always
// ready; write it only while no item is in flight.
module refract_direction (
  input  logic               clk,
  input  logic               rst_n,
  // item input
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic signed [15:0] in_dir_z,
  input  logic signed [15:0] in_norm_x,
  input  logic signed [15:0] in_norm_y,
  input  logic signed [15:0] in_norm_z,
  input  logic        [15:0] in_eta,
  // result output
  output logic               out_valid,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic        [1:0]  out_status,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [30:0] cfg_data
);

  `include "refract_direction_defines.svh"

  localparam int SQ1_RAD_W = 62;
  localparam int SQ1_LAT   = SQ1_RAD_W / 2 + 1;
  localparam int SQ2_RAD_W = 64;
  localparam int SQ2_LAT   = SQ2_RAD_W / 2 + 1;
  localparam int DIV_LAT   = 32;
  localparam int PIPE_LAT  = 2 + SQ1_LAT + 1 + DIV_LAT + 8 + SQ2_LAT + 3;

  logic accept;
  assign busy      = 1'b0;
  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  // Threshold register
  logic [30:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= rd_pkg::THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  // ---------------- stage 1: capture item
  logic               v1_r;
  logic signed [15:0] d1_r [3];
  logic signed [15:0] n1_r [3];
  logic        [15:0] eta1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    d1_r[0] <= in_dir_x;
    d1_r[1] <= in_dir_y;
    d1_r[2] <= in_dir_z;
    n1_r[0] <= in_norm_x;
    n1_r[1] <= in_norm_y;
    n1_r[2] <= in_norm_z;
    eta1_r  <= in_eta;
  end

  // ---------------- stage 2: squared length
  logic               v2_r;
  logic        [31:0] sq2_r;
  logic signed [15:0] d2_r [3];
  logic signed [15:0] n2_r [3];
  logic        [15:0] eta2_r;
  logic signed [31:0] dsq [3];
  logic        [31:0] sq_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsq[i] = d1_r[i] * d1_r[i];
    end
    sq_nxt = unsigned'(dsq[0]) + unsigned'(dsq[1]) + unsigned'(dsq[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sq2_r  <= sq_nxt;
    d2_r   <= d1_r;
    n2_r   <= n1_r;
    eta2_r <= eta1_r;
  end

  // ---------------- length = round(sqrt(sq * 2^30))
  logic        rt1_vld;
  logic [31:0] rt1_root;

  rd_sqrt #(.RAD_W(SQ1_RAD_W)) u_len_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (v2_r),
    .rad     ({sq2_r, 30'd0}),
    .out_vld (rt1_vld),
    .root    (rt1_root)
  );

  logic [112:0]       dla_out;
  logic signed [15:0] da [3];
  logic signed [15:0] na [3];
  logic        [15:0] etaa;
  logic               zeroa;

  rd_delay #(.W(113), .N(SQ1_LAT)) u_dly_a (
    .clk  (clk),
    .din  ({d2_r[0], d2_r[1], d2_r[2], n2_r[0], n2_r[1], n2_r[2], eta2_r,
            (sq2_r == 32'd0)}),
    .dout (dla_out)
  );
  assign {da[0], da[1], da[2], na[0], na[1], na[2], etaa, zeroa} = dla_out;

  // ---------------- stage 3: rounded numerators for normalisation
  logic               v3_r;
  logic        [60:0] num3_r [3];
  logic        [30:0] den3_r;
  logic        [2:0]  sgn3_r;
  logic signed [15:0] n3_r [3];
  logic        [15:0] eta3_r;
  logic               zero3_r;
  logic        [15:0] dmag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag[i] = da[i][15] ? unsigned'(-da[i]) : unsigned'(da[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= rt1_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      num3_r[i] <= {dmag[i], 45'd0} + {31'd0, rt1_root[30:1]};
      sgn3_r[i] <= da[i][15];
    end
    den3_r  <= rt1_root[30:0];
    n3_r    <= na;
    eta3_r  <= etaa;
    zero3_r <= zeroa;
  end

  // ---------------- unit direction magnitudes, Q.30
  logic [2:0]  dv_vld;
  logic [31:0] quo [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    rd_div #(.NUM_W(61), .DEN_W(31), .Q_W(DIV_LAT)) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (v3_r),
      .num     (num3_r[i]),
      .den     (den3_r),
      .out_vld (dv_vld[i]),
      .quo     (quo[i])
    );
  end

  logic [67:0]        dlb_out;
  logic [2:0]         sgnb;
  logic signed [15:0] nb [3];
  logic        [15:0] etab;
  logic               zerob;

  rd_delay #(.W(68), .N(DIV_LAT)) u_dly_b (
    .clk  (clk),
    .din  ({sgn3_r, n3_r[0], n3_r[1], n3_r[2], eta3_r, zero3_r}),
    .dout (dlb_out)
  );
  assign {sgnb, nb[0], nb[1], nb[2], etab, zerob} = dlb_out;

  // ---------------- stage 4: signed unit vector V
  logic               v4_r;
  logic signed [31:0] vec4_r [3];
  logic signed [15:0] n4_r [3];
  logic        [15:0] eta4_r;
  logic               zero4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= &dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      vec4_r[i] <= sgnb[i] ? -signed'(quo[i]) : signed'(quo[i]);
    end
    n4_r    <= nb;
    eta4_r  <= etab;
    zero4_r <= zerob;
  end

  // V, N, eta and the zero flag ride alongside to stage 11
  logic [160:0]       dld_out;
  logic signed [31:0] vd [3];
  logic signed [15:0] nd [3];
  logic        [15:0] etad;
  logic               zerod;

  rd_delay #(.W(161), .N(7)) u_dly_d (
    .clk  (clk),
    .din  ({vec4_r[0], vec4_r[1], vec4_r[2], n4_r[0], n4_r[1], n4_r[2], eta4_r,
            zero4_r}),
    .dout (dld_out)
  );
  assign {vd[0], vd[1], vd[2], nd[0], nd[1], nd[2], etad, zerod} = dld_out;

  // ---------------- stage 5: N.V partial products, Q.44
  logic               v5_r;
  logic signed [46:0] prod5_r [3];
  logic        [15:0] eta5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod5_r[i] <= n4_r[i] * vec4_r[i];
    end
    eta5_r <= eta4_r;
  end

  // ---------------- stage 6: cosI = -round(N.V >> 14), Q.30
  logic               v6_r;
  logic signed [35:0] cos6_r;
  logic        [15:0] eta6_r;
  logic signed [48:0] dot;
  logic signed [48:0] dot_rnd;
  logic signed [34:0] dot_sh;

  always_comb begin
    dot     = 49'(prod5_r[0]) + 49'(prod5_r[1]) + 49'(prod5_r[2]);
    dot_rnd = dot + 49'sd8192;
    dot_sh  = 35'(dot_rnd >>> 14);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    cos6_r <= -(36'(dot_sh));
    eta6_r <= eta5_r;
  end

  // ---------------- stage 7: |cosI|, eta*cosI, eta^2
  logic               v7_r;
  logic        [32:0] c7_r;
  logic signed [52:0] k44_7_r;
  logic        [31:0] e2_7_r;
  logic signed [35:0] cos_neg;

  assign cos_neg = -cos6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    c7_r    <= cos6_r[35] ? cos_neg[32:0] : cos6_r[32:0];
    k44_7_r <= signed'({1'b0, eta6_r}) * cos6_r;
    e2_7_r  <= eta6_r * eta6_r;
  end

  // ---------------- stage 8: cosI^2 and round(eta*cosI >> 14)
  logic               v8_r;
  logic        [63:0] cc8_r;
  logic signed [38:0] k30a8_r;
  logic        [31:0] e2_8_r;
  logic        [65:0] cc_full;
  logic signed [52:0] k44_rnd;

  always_comb begin
    cc_full = c7_r * c7_r;
    k44_rnd = k44_7_r + 53'sd8192;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    cc8_r   <= cc_full[63:0];
    k30a8_r <= 39'(k44_rnd >>> 14);
    e2_8_r  <= e2_7_r;
  end

  // ---------------- stage 9: 1 - cosI^2, Q.28
  logic               v9_r;
  logic signed [33:0] s28_9_r;
  logic signed [38:0] k30a9_r;
  logic        [31:0] e2_9_r;
  logic        [64:0] cc_rnd;

  assign cc_rnd = {1'b0, cc8_r} + 65'd2147483648;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else begin
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    s28_9_r <= 34'sd268435456 - signed'({1'b0, cc_rnd[64:32]});
    k30a9_r <= k30a8_r;
    e2_9_r  <= e2_8_r;
  end

  // ---------------- stage 10: eta^2 * |1 - cosI^2|, Q.56
  logic               v10_r;
  logic        [63:0] p10_r;
  logic               neg10_r;
  logic signed [38:0] k30a10_r;
  logic signed [33:0] s28_neg;
  logic        [32:0] s28_mag;
  logic        [64:0] p_full;

  always_comb begin
    s28_neg = -s28_9_r;
    s28_mag = s28_9_r[33] ? s28_neg[32:0] : s28_9_r[32:0];
    p_full  = e2_9_r * s28_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else begin
      v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    p10_r    <= p_full[63:0];
    neg10_r  <= s28_9_r[33];
    k30a10_r <= k30a9_r;
  end

  // ---------------- stage 11: cosT2, Q.30
  logic               v11_r;
  logic signed [40:0] cost11_r;
  logic signed [38:0] k30a11_r;
  logic        [64:0] p_rnd;
  logic signed [39:0] t_pos;
  logic signed [39:0] t30;
  logic               tir11;

  always_comb begin
    p_rnd = {1'b0, p10_r} + 65'd33554432;
    t_pos = signed'({1'b0, p_rnd[64:26]});
    t30   = neg10_r ? -t_pos : t_pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v11_r <= 1'b0;
    end else begin
      v11_r <= v10_r;
    end
  end

  always_ff @(posedge clk) begin
    cost11_r <= 41'sd1073741824 - 41'(t30);
    k30a11_r <= k30a10_r;
  end

  // Total internal reflection when cosT2 is not above the threshold
  assign tir11 = (cost11_r <= signed'({10'd0, thr_r}));

  // ---------------- sqrt(cosT2) to nearest in Q.28
  logic        rt2_vld;
  logic [32:0] rt2_root;

  rd_sqrt #(.RAD_W(SQ2_RAD_W)) u_cos_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (v11_r),
    .rad     ({cost11_r[37:0], 26'd0}),
    .out_vld (rt2_vld),
    .root    (rt2_root)
  );

  logic [200:0]       dlc_out;
  logic               tirc;
  logic signed [38:0] k30ac;
  logic signed [31:0] vc [3];
  logic signed [15:0] nc [3];
  logic        [15:0] etac;
  logic               zeroc;

  rd_delay #(.W(201), .N(SQ2_LAT)) u_dly_c (
    .clk  (clk),
    .din  ({tir11, k30a11_r, vd[0], vd[1], vd[2], nd[0], nd[1], nd[2], etad,
            zerod}),
    .dout (dlc_out)
  );
  assign {tirc, k30ac, vc[0], vc[1], vc[2], nc[0], nc[1], nc[2], etac, zeroc} = dlc_out;

  // ---------------- stage 12: k = eta*cosI - sqrt(cosT2), Q.30
  logic               v12_r;
  logic signed [40:0] k30_12_r;
  logic signed [31:0] vec12_r [3];
  logic signed [15:0] n12_r [3];
  logic        [15:0] eta12_r;
  logic               zero12_r;
  logic               tir12_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v12_r <= 1'b0;
    end else begin
      v12_r <= rt2_vld;
    end
  end

  always_ff @(posedge clk) begin
    k30_12_r <= 41'(k30ac) - signed'({7'd0, rt2_root[31:0], 2'b00});
    vec12_r  <= vc;
    n12_r    <= nc;
    eta12_r  <= etac;
    zero12_r <= zeroc;
    tir12_r  <= tirc;
  end

  // ---------------- stage 13: eta*V and N*k, Q.44
  logic               v13_r;
  logic signed [48:0] a13_r [3];
  logic signed [56:0] b13_r [3];
  logic               zero13_r;
  logic               tir13_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v13_r <= 1'b0;
    end else begin
      v13_r <= v12_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      a13_r[i] <= signed'({1'b0, eta12_r}) * vec12_r[i];
      b13_r[i] <= n12_r[i] * k30_12_r;
    end
    zero13_r <= zero12_r;
    tir13_r  <= tir12_r;
  end

  // ---------------- stage 14: sum, round to Q.14, saturate, status
  logic signed [57:0] acc     [3];
  logic signed [27:0] acc_sh  [3];
  logic signed [15:0] sat_val [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i]    = 58'(a13_r[i]) + 58'(b13_r[i]) + 58'sd536870912;
      acc_sh[i] = 28'(acc[i] >>> 30);
      if (acc_sh[i] > 28'sd32767) begin
        sat_val[i] = 16'sd32767;
      end else if (acc_sh[i] < -28'sd32768) begin
        sat_val[i] = -16'sd32768;
      end else begin
        sat_val[i] = 16'(acc_sh[i]);
      end
    end
  end

  logic               out_valid_r;
  logic signed [15:0] out_x_r;
  logic signed [15:0] out_y_r;
  logic signed [15:0] out_z_r;
  rd_pkg::status_t    out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v13_r;
    end
  end

  // Zero direction wins over total internal reflection
  always_ff @(posedge clk) begin
    if (zero13_r) begin
      out_x_r      <= '0;
      out_y_r      <= '0;
      out_z_r      <= '0;
      out_status_r <= rd_pkg::ST_ZERO;
    end else if (tir13_r) begin
      out_x_r      <= '0;
      out_y_r      <= '0;
      out_z_r      <= '0;
      out_status_r <= rd_pkg::ST_TIR;
    end else begin
      out_x_r      <= sat_val[0];
      out_y_r      <= sat_val[1];
      out_z_r      <= sat_val[2];
      out_status_r <= rd_pkg::ST_PASS;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_z      = out_z_r;
  assign out_status = out_status_r;

  // ---------------- checks
  `RD_ASSERT_AFTER(a_lat_fwd, accept, PIPE_LAT, out_valid)
  `RD_ASSERT_NOW(a_lat_back, out_valid, $past(accept, PIPE_LAT))
  `RD_ASSERT_NOW(a_zero_vec, out_valid && (out_status != rd_pkg::ST_PASS),
                 (out_x == 16'sd0) && (out_y == 16'sd0) && (out_z == 16'sd0))
  `RD_ASSERT_NEXT(a_cfg_wr, cfg_valid && cfg_ready, thr_r == $past(cfg_data))

endmodule

FILE: dv/refract_direction_tb.sv
// ----------------------------------------------------------------------------
// refract_direction_tb
// Self-checking bench for the Snell refraction datapath. A directed table
// covers zero direction, axis rays, full-scale fields, grazing and total
// internal reflection; random rays then follow under several thresholds.
// Every result is compared with its table value or a bit-true fixed-point predictor.
// ----------------------------------------------------------------------------
module refract_direction_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 111;
  localparam int WDOG_MAX  = 4000;
  localparam int N_RANDOM  = 1900;

  typedef struct {
    logic signed [15:0] dx, dy, dz, nx, ny, nz;
    logic        [15:0] eta;
  } ray_t;

  typedef struct {
    logic signed [15:0] x, y, z;
    rd_pkg::status_t    st;
  } refr_t;

  typedef struct {
    ray_t  r;
    bit    typed;   // expected value written in the table
    refr_t want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic signed [15:0] in_norm_x = '0, in_norm_y = '0, in_norm_z = '0;
  logic        [15:0] in_eta = '0;
  logic               out_valid;
  logic signed [15:0] out_x, out_y, out_z;
  logic        [1:0]  out_status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic        [30:0] cfg_data = '0;

  refract_direction DUT (.*);

  refr_t       refr_q[$];
  logic [30:0] thresh;
  int          n_err = 0;
  int          idle_cnt = 0;
  bit          quiet = 1'b0;   // long stretch without sender gaps

  initial forever #1 clk = ~clk;

  // round to nearest, ties up
  function automatic longint rnd_shr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint unsigned sqrt_rn(longint unsigned x);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (x > r) r++;
    return r;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic refr_t refract(ray_t r);
    refr_t o;
    longint d[3], n[3], v[3], acc, cosi, s28, t30, cost2, root30, k30;
    longint unsigned sq, len, m, c, c2, t, e;
    o.x = 0; o.y = 0; o.z = 0;
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    n[0] = r.nx; n[1] = r.ny; n[2] = r.nz;
    e = r.eta;
    sq = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
    if (sq == 0) begin
      o.st = rd_pkg::ST_ZERO;
      return o;
    end
    len = sqrt_rn(sq << 30);
    for (int i = 0; i < 3; i++) begin
      m = (((d[i] < 0 ? -d[i] : d[i]) << 45) + (len >> 1)) / len;
      v[i] = d[i] < 0 ? -longint'(m) : longint'(m);
    end
    acc = n[0]*v[0] + n[1]*v[1] + n[2]*v[2];
    cosi = -rnd_shr(acc, 14);
    c = cosi < 0 ? -cosi : cosi;
    c2 = (c * c + (64'd1 << 31)) >> 32;
    s28 = (longint'(1) << 28) - longint'(c2);
    t = (e * e * (s28 < 0 ? -s28 : s28) + (64'd1 << 25)) >> 26;
    t30 = s28 < 0 ? -longint'(t) : longint'(t);
    cost2 = (longint'(1) << 30) - t30;
    if (cost2 <= longint'(thresh)) begin
      o.st = rd_pkg::ST_TIR;
      return o;
    end
    root30 = longint'(sqrt_rn(longint'(cost2) << 26) << 2);
    k30 = rnd_shr(longint'(e) * cosi, 14) - root30;
    o.x = clip16(rnd_shr(longint'(e) * v[0] + n[0] * k30, 30));
    o.y = clip16(rnd_shr(longint'(e) * v[1] + n[1] * k30, 30));
    o.z = clip16(rnd_shr(longint'(e) * v[2] + n[2] * k30, 30));
    o.st = rd_pkg::ST_PASS;
    return o;
  endfunction

  // result checker and watchdog
  always @(posedge clk) begin
    refr_t w;
    if (rst_n) begin
      idle_cnt <= (out_valid || (start && !busy) || cfg_valid) ? 0 : idle_cnt + 1;
      if (idle_cnt >= WDOG_MAX) begin
        $display("%0t watchdog: no activity", $time);
        $display("refract_direction_tb: errors");
        $finish;
      end
      if (out_valid) begin
        if (refr_q.size() == 0) begin
          $display("%0t unexpected result %0d %0d %0d st %0d", $time,
                   out_x, out_y, out_z, out_status);
          n_err++;
        end else begin
          w = refr_q.pop_front();
          if (out_x !== w.x || out_y !== w.y || out_z !== w.z || out_status !== w.st) begin
            $display("%0t mismatch exp %0d %0d %0d st %0d act %0d %0d %0d st %0d",
                     $time, w.x, w.y, w.z, w.st, out_x, out_y, out_z, out_status);
            n_err++;
          end
        end
      end
    end
  end

  task automatic send_ray(ray_t r, bit typed, refr_t want);
    while (!quiet && $urandom_range(99) < 6) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_dir_x <= r.dx; in_dir_y <= r.dy; in_dir_z <= r.dz;
    in_norm_x <= r.nx; in_norm_y <= r.ny; in_norm_z <= r.nz;
    in_eta <= r.eta;
    do @(posedge clk); while (busy);
    refr_q.push_back(typed ? want : refract(r));
  endtask

  task automatic write_thresh(logic [30:0] val);
    start <= 1'b0;
    while (refr_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thresh = val;
  endtask

  function automatic ray_t rand_ray();
    ray_t r;
    int sel = $urandom_range(9);
    r.dx = 16'($urandom); r.dy = 16'($urandom); r.dz = 16'($urandom);
    r.eta = 16'($urandom);
    if (sel < 7) begin
      // realistic: near-unit normal along the z axis, mild eta, some short rays
      r.nx = 16'($signed($urandom_range(2000)) - 1000);
      r.ny = 16'($signed($urandom_range(2000)) - 1000);
      r.nz = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      r.nz = r.nz + 16'($signed($urandom_range(200)) - 100);
      r.eta = 16'($urandom_range(8192, 32768));
      if (sel < 3) begin
        r.dx = $signed(16'($urandom)) >>> $urandom_range(12);
        r.dy = $signed(16'($urandom)) >>> $urandom_range(12);
        r.dz = $signed(16'($urandom)) >>> $urandom_range(12);
      end
    end else begin
      r.nx = 16'($urandom); r.ny = 16'($urandom); r.nz = 16'($urandom);
    end
    return r;
  endfunction

  row_t dir_tab[] = '{
    '{'{0, 0, 0, 16384, 0, 0, 16384}, 1, '{0, 0, 0, rd_pkg::ST_ZERO}},
    '{'{0, 0, 0, -32768, -32768, -32768, 65535}, 1, '{0, 0, 0, rd_pkg::ST_ZERO}},
    '{'{0, 0, -4096, 0, 0, 16384, 16384}, 0, '{0, 0, 0, rd_pkg::ST_PASS}},
    '{'{0, 0, -4096, 0, 0, 16384, 0}, 0, '{0, 0, 0, rd_pkg::ST_PASS}},
    '{'{4096, 0, -4096, 0, 0, 16384, 24576}, 0, '{0, 0, 0, rd_pkg::ST_PASS}},
    '{'{4096, 0, -1, 0, 0, 16384, 24576}, 0, '{0, 0, 0, rd_pkg::ST_PASS}},
    '{'{4096, 0, 0, 0, 0, 16384, 16384}, 0, '{0, 0, 0, rd_pkg::ST_PASS}},
    '{'{4096, 0, 0, 0, 0, 16384, 16385}, 0, '{0, 0, 0, rd_pkg::ST_PASS}},
    '{'{32767, 32767, 32767, 32767, 32767, 32767, 65535}, 0,
      '{0, 0, 0, rd_pkg::ST_PASS}},
    '{'{-32768, -32768, -32768, -32768, -32768, -32768, 65535}, 0,
      '{0, 0, 0, rd_pkg::ST_PASS}},
    '{'{-32768, 32767, -32768, 32767, -32768, 32767, 0}, 0,
      '{0, 0, 0, rd_pkg::ST_PASS}},
    '{'{1, 0, 0, -16384, 0, 0, 16384}, 0, '{0, 0, 0, rd_pkg::ST_PASS}},
    '{'{0, -1, 0, 0, 16384, 0, 65535}, 0, '{0, 0, 0, rd_pkg::ST_PASS}},
    '{'{0, 0, 1, 0, 0, 0, 16384}, 0, '{0, 0, 0, rd_pkg::ST_PASS}},
    '{'{3000, -2000, -4000, 0, 0, 16384, 8192}, 0, '{0, 0, 0, rd_pkg::ST_PASS}},
    '{'{3000, -2000, -4000, 0, 0, 16384, 40000}, 0, '{0, 0, 0, rd_pkg::ST_PASS}},
    '{'{-5, 7, -3, 9000, -9000, 9000, 20000}, 0, '{0, 0, 0, rd_pkg::ST_PASS}}
  };

  // stimulus
  initial begin
    logic [30:0] th_set[4] = '{31'd0, 31'h4000_0000, 31'h7FFF_FFFF, 31'd5000000};
    thresh = rd_pkg::THRESH_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) send_ray(dir_tab[i].r, dir_tab[i].typed, dir_tab[i].want);
    for (int p = 0; p < 5; p++) begin
      if (p > 0) write_thresh(p == 4 ? 31'($urandom) : th_set[p - 1]);
      for (int k = 0; k < N_RANDOM / 5; k++) begin
        quiet = (p == 1 && k > 100 && k < 300);
        send_ray(rand_ray(), 1'b0, refr_t'{0, 0, 0, rd_pkg::ST_PASS});
      end
    end
    start <= 1'b0;
    while (refr_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (n_err == 0) $display("refract_direction_tb: clean");
    else $display("refract_direction_tb: errors");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/rd_pkg.sv
hdl/rd_delay.sv
hdl/rd_sqrt.sv
hdl/rd_div.sv
hdl/refract_direction.sv
dv/refract_direction_tb.sv
